/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_BITS   = 32;
	localparam int PRIO_BITS    = 8;
	localparam int COUNT_BITS   = 5;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_FRONT = 2'd2
	} spq_cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef struct packed {
		logic [1:0]            command;
		logic [VALUE_BITS-1:0] item_value;
		logic [PRIO_BITS-1:0]  item_priority;
	} spq_in_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] head_value;
		logic [1:0]            status;
		logic [COUNT_BITS-1:0] entry_count;
	} spq_out_t;

	// operation broadcast to every cell of the chain
	typedef struct packed {
		logic                  push;
		logic                  pop;
		logic [PRIO_BITS-1:0]  prio;
		logic [VALUE_BITS-1:0] value;
	} spq_op_t;

	// what one cell shows its neighbors
	typedef struct packed {
		logic                  keep;
		logic [PRIO_BITS-1:0]  prio;
		logic [VALUE_BITS-1:0] value;
	} spq_slot_t;

endpackage

/* sv/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic      clk,
	input  spq_op_t   op,
	input  logic      occupied,
	input  spq_slot_t left,
	input  spq_slot_t right,
	output spq_slot_t slot
);

	logic [PRIO_BITS-1:0]  prio_q;
	logic [VALUE_BITS-1:0] value_q;

	// entry stays ahead of a new push of equal or lower priority
	assign slot.keep  = occupied && (prio_q >= op.prio);
	assign slot.prio  = prio_q;
	assign slot.value = value_q;

	always_ff @(posedge clk) begin
		if (op.push && !slot.keep) begin
			if (left.keep) begin
				prio_q  <= op.prio;
				value_q <= op.value;
			end else begin
				prio_q  <= left.prio;
				value_q <= left.value;
			end
		end else if (op.pop) begin
			prio_q  <= right.prio;
			value_q <= right.value;
		end
	end

endmodule

/* sv/sorted_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept sorted in a chain of register cells.
// ----------------------------------------------------------------------------
// Takes one push, pop or front per clock while in_ready is high. Every slot
// compares its priority with the pushed one in parallel, so a push makes room
// and a pop shifts the whole chain one place toward the head. Each transfer
// on the input gives exactly one result, registered in the next cycle; the
// input stays ready while the result register is empty or being drained, so
// back-to-back transfers run at one per cycle. Equal priorities leave in
// arrival order. Pop/front on an empty queue reports empty; a push to a full
// queue is dropped and reports full. Slot contents are not reset, only the
// entry count and the result valid flag.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  spq_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output spq_out_t out_data
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic          out_valid_q;
	spq_out_t      out_data_q;
	spq_out_t      result;
	spq_op_t       op;
	logic          accept;
	logic          full;
	logic          empty;

	spq_slot_t slots [CAPACITY];

	assign accept = in_valid && in_ready;
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);

	// decode the command against the current fill level
	always_comb begin
		op.push            = 1'b0;
		op.pop             = 1'b0;
		op.prio            = in_data.item_priority;
		op.value           = in_data.item_value;
		count_nxt          = count_q;
		result.head_value  = '0;
		result.status      = ST_OK;
		case (spq_cmd_t'(in_data.command))
			CMD_PUSH: begin
				if (full) begin
					result.status = ST_FULL;
				end else begin
					op.push   = accept;
					count_nxt = count_q + CW'(1);
				end
			end
			CMD_POP: begin
				if (empty) begin
					result.status = ST_EMPTY;
				end else begin
					op.pop            = accept;
					result.head_value = slots[0].value;
					count_nxt         = count_q - CW'(1);
				end
			end
			CMD_FRONT: begin
				if (empty) begin
					result.status = ST_EMPTY;
				end else begin
					result.head_value = slots[0].value;
				end
			end
			default: begin
			end
		endcase
		// the count is cut to the field width
		result.entry_count = COUNT_BITS'(count_nxt);
	end

	// the chain: slot 0 is the head, new entries enter from the left
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_slot_t left_in;
		spq_slot_t right_in;

		if (i == 0) begin : g_head
			assign left_in = '{keep: 1'b1, prio: op.prio, value: op.value};
		end else begin : g_mid
			assign left_in = slots[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_in = slots[i];
		end else begin : g_body
			assign right_in = slots[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.op       (op),
			.occupied (CW'(i) < count_q),
			.left     (left_in),
			.right    (right_in),
			.slot     (slots[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

	// result register frees up as it is drained
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* sv/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue core.
// ----------------------------------------------------------------------------
module spq_checker
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input spq_out_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// every input transfer leaves a result pending next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("input transfer produced no result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |->
			out_data.entry_count == COUNT_BITS'(CAPACITY) && out_data.head_value == '0)
		else $error("full status with wrong count or head");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |->
			out_data.entry_count == '0 && out_data.head_value == '0)
		else $error("empty status with wrong count or head");

endmodule

bind sorted_priority_queue_core spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* tb/sorted_priority_queue_core_tb.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_tb
// Self-checking testbench for the sorted priority queue core.
// ----------------------------------------------------------------------------
// A shadow copy of the sorted slot list predicts every reply. The expected
// replies are matched in order against what leaves the output channel. A
// short directed sequence hits the edge cases. Random traffic follows in
// fill, drain and mixed bursts, under four flow-control phases: none,
// sender gaps, receiver stalls, and light gaps on both sides.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_tb;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          DEPTH      = CAPACITY_DEF;
	localparam int          IDLE_LIMIT = 5000;  // cycles with no transfer before timeout
	localparam int          TAIL_WAIT  = 4;     // result latency plus margin
	localparam logic [1:0]  CMD_NOP    = 2'd3;  // unused code, must be a no-op

	// Shadow of the queue: sorted slots plus the replies still awaited.
	class queue_shadow;
		logic [PRIO_BITS-1:0]  slot_prio [DEPTH];
		logic [VALUE_BITS-1:0] slot_val  [DEPTH];
		int                    fill;
		spq_out_t              awaited_replies [$];
		int                    errors;
		int                    n_push, n_pop, n_front, n_nop, n_full, n_empty, n_seen;

		function new();
			fill    = 0;
			errors  = 0;
			n_push  = 0;
			n_pop   = 0;
			n_front = 0;
			n_nop   = 0;
			n_full  = 0;
			n_empty = 0;
			n_seen  = 0;
		endfunction

		// Apply one accepted request to the shadow and queue its reply.
		function void take_request(spq_in_t req);
			spq_out_t rep;
			int       pos;
			rep = '0;
			case (req.command)
				CMD_PUSH: begin
					n_push++;
					if (fill >= DEPTH) begin
						rep.status = ST_FULL;
						n_full++;
					end else begin
						// insert behind every entry of equal or higher priority
						pos = 0;
						while (pos < fill && slot_prio[pos] >= req.item_priority)
							pos++;
						for (int i = fill; i > pos; i--) begin
							slot_prio[i] = slot_prio[i-1];
							slot_val[i]  = slot_val[i-1];
						end
						slot_prio[pos] = req.item_priority;
						slot_val[pos]  = req.item_value;
						fill++;
						rep.status = ST_OK;
					end
				end
				CMD_POP, CMD_FRONT: begin
					if (req.command == CMD_POP)
						n_pop++;
					else
						n_front++;
					if (fill == 0) begin
						rep.status = ST_EMPTY;
						n_empty++;
					end else begin
						rep.head_value = slot_val[0];
						rep.status     = ST_OK;
						if (req.command == CMD_POP) begin
							for (int i = 0; i + 1 < fill; i++) begin
								slot_prio[i] = slot_prio[i+1];
								slot_val[i]  = slot_val[i+1];
							end
							fill--;
						end
					end
				end
				default: begin
					n_nop++;
					rep.status = ST_OK;
				end
			endcase
			rep.entry_count = fill[COUNT_BITS-1:0];
			awaited_replies.push_back(rep);
		endfunction

		// Compare one reply from the block with the oldest awaited one.
		function void match_reply(spq_out_t got);
			spq_out_t want;
			n_seen++;
			if (awaited_replies.size() == 0) begin
				$error("unexpected reply: head_value %0h status %0d entry_count %0d",
					got.head_value, got.status, got.entry_count);
				errors++;
				return;
			end
			want = awaited_replies.pop_front();
			if (got.head_value !== want.head_value) begin
				$error("head_value: expected %0h, actual %0h", want.head_value, got.head_value);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, actual %0d",
					want.entry_count, got.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	spq_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b1;
	spq_out_t out_data;

	queue_shadow shadow;
	int          send_gap_pct   = 0;  // chance per cycle that the sender idles
	int          recv_stall_pct = 0;  // chance per cycle that the receiver stalls
	int          quiet_cycles   = 0;

	sorted_priority_queue_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: both channels are sampled at the edge where a transfer happens.
	// The request is noted before the reply check; a reply is registered and so
	// always trails its request, so this order never matters for a pair.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				shadow.take_request(in_data);
			if (out_valid && out_ready)
				shadow.match_reply(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("sorted_priority_queue_core_tb: errors");
				$finish;
			end
		end
	end

	// Offer one request and hold it until the transfer. Valid is only dropped
	// when the sender takes a gap, so back-to-back requests keep it high.
	task automatic issue_op(input spq_in_t req);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic issue(input logic [1:0] cmd, input logic [VALUE_BITS-1:0] val,
			input logic [PRIO_BITS-1:0] prio);
		spq_in_t req;
		req.command       = cmd;
		req.item_value    = val;
		req.item_priority = prio;
		issue_op(req);
	endtask

	// Random request with the given push/pop weights in percent; the rest
	// goes to front, with a thin slice of the unused code.
	function automatic spq_in_t rand_op(input int push_pct, input int pop_pct);
		spq_in_t req;
		int      pick;
		pick = $urandom_range(99);
		if (pick < push_pct)
			req.command = CMD_PUSH;
		else if (pick < push_pct + pop_pct)
			req.command = CMD_POP;
		else if (pick < 97)
			req.command = CMD_FRONT;
		else
			req.command = CMD_NOP;
		case ($urandom_range(9))
			0:       req.item_value = '0;
			1:       req.item_value = '1;
			default: req.item_value = $urandom;
		endcase
		pick = $urandom_range(9);
		if (pick < 5)
			req.item_priority = PRIO_BITS'($urandom_range(3));     // crowd equal priorities
		else if (pick < 9)
			req.item_priority = PRIO_BITS'($urandom_range(255));
		else
			req.item_priority = $urandom_range(1) ? '1 : '0;
		return req;
	endfunction

	// One phase of random traffic: fill, drain, mixed, then fill again.
	task automatic random_phase(input int gap_pct, input int stall_pct);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		for (int seg = 0; seg < 4; seg++) begin
			for (int n = 0; n < 47; n++) begin
				case (seg)
					0, 3:    issue_op(rand_op(75, 15));
					1:       issue_op(rand_op(20, 65));
					default: issue_op(rand_op(45, 40));
				endcase
			end
		end
	endtask

	initial begin
		shadow = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-queue reads, extreme fields, ties, the unused code.
		issue(CMD_FRONT, 32'h1234_5678, 8'hAA);
		issue(CMD_POP,   32'hDEAD_BEEF, 8'h55);
		issue(CMD_NOP,   32'hFFFF_FFFF, 8'hFF);
		issue(CMD_PUSH,  '0,            '0);
		issue(CMD_PUSH,  '1,            '1);
		issue(CMD_PUSH,  32'h0000_0011, 8'h80);
		issue(CMD_PUSH,  32'h0000_0022, 8'h80);   // tie: must follow the 0x11 entry
		issue(CMD_PUSH,  32'h0000_0033, 8'h80);
		issue(CMD_PUSH,  32'hAAAA_5555, '0);      // tie at the lowest priority
		issue(CMD_FRONT, '0,            '0);
		issue(CMD_NOP,   '0,            '0);
		issue(CMD_POP,   '0,            '0);
		issue(CMD_FRONT, '0,            '0);
		issue(CMD_POP,   '0,            '0);
		issue(CMD_POP,   '0,            '0);
		issue(CMD_PUSH,  32'h5555_AAAA, 8'hFF);   // new head ahead of the rest
		issue(CMD_POP,   '0,            '0);
		issue(CMD_POP,   '0,            '0);
		issue(CMD_POP,   '0,            '0);
		issue(CMD_POP,   '0,            '0);
		issue(CMD_POP,   '0,            '0);      // pop on an empty queue
		issue(CMD_FRONT, '0,            '0);

		// Random: no idling, sender gaps, receiver stalls, then both lightly.
		random_phase(0, 0);
		random_phase(70, 0);
		random_phase(0, 70);
		random_phase(10, 10);

		in_valid <= 1'b0;
		@(posedge clk);
		while (shadow.awaited_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (shadow.awaited_replies.size() != 0) begin
			$error("%0d replies never arrived", shadow.awaited_replies.size());
			shadow.errors++;
		end

		$display("covered %0d pushes (%0d refused when full), %0d pops, %0d fronts, %0d no-ops",
			shadow.n_push, shadow.n_full, shadow.n_pop, shadow.n_front, shadow.n_nop);
		$display("%0d reads hit an empty queue; %0d replies checked, %0d mismatches",
			shadow.n_empty, shadow.n_seen, shadow.errors);
		if (shadow.errors == 0)
			$display("sorted_priority_queue_core_tb: clean");
		else
			$display("sorted_priority_queue_core_tb: errors");
		$finish;
	end

endmodule
